@@ rtl/core/rtps_pkg.sv @@
// ----------------------------------------------------------------------------
// rtps_pkg
// Shared types, constants and helpers of the region to TLB page splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtps_pkg;

  localparam int ADDR_W   = 32;
  localparam int MASK_W   = 29;
  localparam int SIZE_W   = 30;
  localparam int ID_W     = 8;
  localparam int SIDX_W   = 6;
  localparam int ERR_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_K    = 8;

  localparam int DEF_TLB_ENTRIES = 64;

  localparam logic [MASK_W-1:0] MAX_MASK_RESET = 29'h1FFE000;
  localparam logic [MASK_W-1:0] FIRST_BIG      = 29'h0006000;
  localparam logic [SIZE_W-1:0] PAIR_MIN       = 30'h0002000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGE_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_IN_ENTRYHI = 1'd1;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_ALIGN    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PMASK,
    S_PDIST,
    S_GMASK,
    S_GDIST,
    S_CLIP,
    S_SIZE,
    S_EMIT
  } state_t;

  typedef enum logic {
    D_MASK,
    D_DIST
  } dop_t;

  typedef struct packed {
    logic ri;
    logic xi;
    logic d;
  } attr_t;

  // pair size for a page of 4 KiB << 2k
  function automatic logic [SIZE_W-1:0] pair_size(input int k);
    logic [SIZE_W-1:0] s;
    s = SIZE_W'(32'h2000 << (2 * k));
    return s;
  endfunction

  function automatic logic [MASK_W-1:0] pair_mask(input int k);
    logic [SIZE_W-1:0] s;
    s = pair_size(k) - PAIR_MIN;
    return s[MASK_W-1:0];
  endfunction

  // largest valid mask whose bits are all set in the written value
  function automatic logic [MASK_W-1:0] eff_max(input logic [MASK_W-1:0] cfg);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int k = 1; k <= MAX_K; k++) begin
      if ((pair_mask(k) & ~cfg) == '0) m = pair_mask(k);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/region_to_tlb_page_splitter.sv @@
// ----------------------------------------------------------------------------
// region_to_tlb_page_splitter
// Splits a mapping request into paired-page TLB entries, one word per entry.
//
//   channel  handshake             payload
//   in       start / busy          in_host_addr .. in_start_index
//   out      out_valid (strobe)    out_entry_index .. out_error_code
//   cfg      cfg_we                cfg_index, cfg_data
//
// A request is taken when start is high and busy is low. Each chunk between
// alignment boundaries goes through the shared boundary unit (host mask, host
// distance, guest mask, guest distance, clip), then each entry: size pick, emit.
// Start errors come in the cycle after the request; aligned zero length: no word.
// Synchronous reset restores the config defaults; no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module region_to_tlb_page_splitter import rtps_pkg::*; #(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire [ADDR_W-1:0]      in_host_addr,
  input  wire [ADDR_W-1:0]      in_guest_addr,
  input  wire [ADDR_W-1:0]      in_region_len,
  input  wire [ID_W-1:0]        in_guest_id,
  input  wire                   in_no_read,
  input  wire                   in_read_only,
  input  wire                   in_no_exec,
  input  wire [SIDX_W-1:0]      in_start_index,
  output logic                  out_valid,
  output logic [SIDX_W-1:0]     out_entry_index,
  output logic [ADDR_W-1:0]     out_entry_hi,
  output logic [ADDR_W-1:0]     out_entry_lo0,
  output logic [ADDR_W-1:0]     out_entry_lo1,
  output logic [MASK_W-1:0]     out_page_mask,
  output logic                  out_is_last,
  output logic [ERR_W-1:0]      out_error_code,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [MASK_W-1:0]      cfg_data
);

  localparam int IW = $clog2(TLB_ENTRIES + 1);

  state_t state_r, state_nxt;

  logic [MASK_W-1:0] max_r;
  logic              id_en_r;

  logic [ADDR_W-1:0] pa_r, pa_nxt;
  logic [ADDR_W-1:0] gpa_r, gpa_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  attr_t             attr_r, attr_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [MASK_W-1:0] pn_r, pn_nxt;
  logic [SIZE_W-1:0] dist_r, dist_nxt;
  logic [SIZE_W-1:0] target_r, target_nxt;
  logic [SIZE_W-1:0] ps_r, ps_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [ADDR_W-1:0] out_hi_r, out_hi_nxt;
  logic [ADDR_W-1:0] out_lo0_r, out_lo0_nxt;
  logic [ADDR_W-1:0] out_lo1_r, out_lo1_nxt;
  logic [MASK_W-1:0] out_pm_r, out_pm_nxt;
  logic              out_last_r, out_last_nxt;
  err_t              out_err_r, out_err_nxt;

  dop_t              unit_op;
  logic [ADDR_W-1:0] unit_addr;
  logic [SIZE_W-1:0] unit_res;

  logic [ADDR_W-1:0] fmt_hi, fmt_lo0, fmt_lo1;
  logic [MASK_W-1:0] fmt_pm;

  logic              misaligned;
  logic [SIZE_W-1:0] fit;
  logic [ADDR_W-1:0] len_left;
  logic [IW-1:0]     idx_inc;

  rtps_dist u_dist (
    .op       (unit_op),
    .addr     (unit_addr),
    .max_mask (max_r),
    .pn_in    (pn_r),
    .res      (unit_res)
  );

  rtps_fmt u_fmt (
    .pa   (pa_r),
    .gpa  (gpa_r),
    .ps   (ps_r),
    .attr (attr_r),
    .id   (id_r),
    .hi   (fmt_hi),
    .lo0  (fmt_lo0),
    .lo1  (fmt_lo1),
    .pm   (fmt_pm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_MASK_RESET;
      id_en_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_PAGE_MASK: max_r   <= eff_max(cfg_data);
          CFG_ID_IN_ENTRYHI: id_en_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pa_r       <= pa_nxt;
    gpa_r      <= gpa_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    attr_r     <= attr_nxt;
    id_r       <= id_nxt;
    pn_r       <= pn_nxt;
    dist_r     <= dist_nxt;
    target_r   <= target_nxt;
    ps_r       <= ps_nxt;
    out_idx_r  <= out_idx_nxt;
    out_hi_r   <= out_hi_nxt;
    out_lo0_r  <= out_lo0_nxt;
    out_lo1_r  <= out_lo1_nxt;
    out_pm_r   <= out_pm_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  // largest pair that fits both the target and the page size limit
  always_comb begin
    fit = PAIR_MIN;
    for (int k = 1; k <= MAX_K; k++) begin
      if (pair_size(k) <= target_r && (pair_mask(k) & ~max_r) == '0) fit = pair_size(k);
    end
  end

  always_comb begin
    misaligned = |(in_host_addr[12:0] | in_guest_addr[12:0] | in_region_len[12:0]);
    len_left   = len_r - {2'b00, ps_r};
    idx_inc    = idx_r + IW'(1);

    state_nxt     = state_r;
    pa_nxt        = pa_r;
    gpa_nxt       = gpa_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    attr_nxt      = attr_r;
    id_nxt        = id_r;
    pn_nxt        = pn_r;
    dist_nxt      = dist_r;
    target_nxt    = target_r;
    ps_nxt        = ps_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_hi_nxt    = out_hi_r;
    out_lo0_nxt   = out_lo0_r;
    out_lo1_nxt   = out_lo1_r;
    out_pm_nxt    = out_pm_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    unit_op       = D_MASK;
    unit_addr     = pa_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (misaligned || ({1'b0, in_start_index} >= 7'(TLB_ENTRIES) &&
                             in_region_len != '0)) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = '0;
            out_hi_nxt    = '0;
            out_lo0_nxt   = '0;
            out_lo1_nxt   = '0;
            out_pm_nxt    = '0;
            out_last_nxt  = 1'b1;
            out_err_nxt   = misaligned ? ERR_ALIGN : ERR_OVERFLOW;
          end else if (in_region_len != '0) begin
            pa_nxt    = in_host_addr;
            gpa_nxt   = in_guest_addr;
            len_nxt   = in_region_len;
            idx_nxt   = IW'(in_start_index);
            attr_nxt  = '{ri: in_no_read, xi: in_no_exec, d: ~in_read_only};
            id_nxt    = id_en_r ? in_guest_id : '0;
            state_nxt = S_PMASK;
          end
        end
      end
      S_PMASK: begin
        unit_op   = D_MASK;
        unit_addr = pa_r;
        pn_nxt    = unit_res[MASK_W-1:0];
        state_nxt = S_PDIST;
      end
      S_PDIST: begin
        unit_op   = D_DIST;
        unit_addr = pa_r;
        dist_nxt  = unit_res;
        state_nxt = S_GMASK;
      end
      S_GMASK: begin
        unit_op   = D_MASK;
        unit_addr = gpa_r;
        pn_nxt    = unit_res[MASK_W-1:0];
        state_nxt = S_GDIST;
      end
      S_GDIST: begin
        unit_op   = D_DIST;
        unit_addr = gpa_r;
        if (unit_res < dist_r) dist_nxt = unit_res;
        state_nxt = S_CLIP;
      end
      S_CLIP: begin
        target_nxt = (len_r < {2'b00, dist_r}) ? len_r[SIZE_W-1:0] : dist_r;
        state_nxt  = S_SIZE;
      end
      S_SIZE: begin
        ps_nxt    = fit;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = SIDX_W'(idx_r);
        out_hi_nxt    = fmt_hi;
        out_lo0_nxt   = fmt_lo0;
        out_lo1_nxt   = fmt_lo1;
        out_pm_nxt    = fmt_pm;
        pa_nxt        = pa_r + {2'b00, ps_r};
        gpa_nxt       = gpa_r + {2'b00, ps_r};
        len_nxt       = len_left;
        idx_nxt       = idx_inc;
        target_nxt    = target_r - ps_r;
        if (len_left == '0) begin
          out_last_nxt = 1'b1;
          out_err_nxt  = ERR_NONE;
          state_nxt    = S_IDLE;
        end else if (idx_inc >= IW'(TLB_ENTRIES)) begin
          out_last_nxt = 1'b1;
          out_err_nxt  = ERR_OVERFLOW;
          state_nxt    = S_IDLE;
        end else begin
          out_last_nxt = 1'b0;
          out_err_nxt  = ERR_NONE;
          state_nxt    = (target_r == ps_r) ? S_PMASK : S_SIZE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_entry_index = out_idx_r;
  assign out_entry_hi    = out_hi_r;
  assign out_entry_lo0   = out_lo0_r;
  assign out_entry_lo1   = out_lo1_r;
  assign out_page_mask   = out_pm_r;
  assign out_is_last     = out_last_r;
  assign out_error_code  = out_err_r;

`ifndef SYNTH
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_is_last)
    else $error("error word not marked last");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> busy)
    else $error("non-final word but block idle");

  a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |=> out_valid)
    else $error("emit step without a result word");

  a_mask_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_page_mask[12:0] == '0 && out_entry_hi[12:8] == '0)
    else $error("malformed page mask or entry hi");

  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rtps_dist.sv @@
// ----------------------------------------------------------------------------
// rtps_dist
// Shared boundary unit: page mask one size above what an address alignment allows,
// within the limit, or the distance from the address to the next boundary of a given mask.
// ----------------------------------------------------------------------------
`default_nettype none

module rtps_dist import rtps_pkg::*; (
  input  wire dop_t              op,
  input  wire [ADDR_W-1:0]       addr,
  input  wire [MASK_W-1:0]       max_mask,
  input  wire [MASK_W-1:0]       pn_in,
  output logic [SIZE_W-1:0]      res
);

  logic [ADDR_W-1:0] below_incl;
  logic [ADDR_W-1:0] below;
  logic [ADDR_W-1:0] lowbit;
  logic              even_pos;
  logic [ADDR_W-1:0] lim_full;
  logic [MASK_W-1:0] lim;
  logic [MASK_W-1:0] grown;
  logic [MASK_W-1:0] pn;
  logic [SIZE_W-1:0] span;

  always_comb begin
    below_incl = addr ^ (addr - 32'd1);
    below      = below_incl >> 1;
    lowbit     = below_incl & ~below;
    even_pos   = |(lowbit & 32'h5555_5555);
    lim_full   = even_pos ? (below >> 1) : below;
    lim        = max_mask & lim_full[MASK_W-1:0];
    grown      = ((lim << 2) | lim) & max_mask;
    pn         = (lim != '0) ? grown : FIRST_BIG;
    span       = {1'b0, pn_in} + PAIR_MIN - {1'b0, addr[MASK_W-1:0] & pn_in};
    case (op)
      D_MASK:  res = {1'b0, pn};
      D_DIST:  res = span;
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/rtps_fmt.sv @@
// ----------------------------------------------------------------------------
// rtps_fmt
// Builds EntryHi, EntryLo0/1 and PageMask words of one paired-page entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rtps_fmt import rtps_pkg::*; (
  input  wire [ADDR_W-1:0]   pa,
  input  wire [ADDR_W-1:0]   gpa,
  input  wire [SIZE_W-1:0]   ps,
  input  wire attr_t         attr,
  input  wire [ID_W-1:0]     id,
  output logic [ADDR_W-1:0]  hi,
  output logic [ADDR_W-1:0]  lo0,
  output logic [ADDR_W-1:0]  lo1,
  output logic [MASK_W-1:0]  pm
);

  logic [ADDR_W-1:0] pa_odd;

  always_comb begin
    pa_odd = pa + {3'b000, ps[SIZE_W-1:1]};
    hi     = {gpa[31:13], 5'b00000, id};
    lo0    = {attr.ri, attr.xi, 4'b0000, pa[31:12], 3'b101, attr.d, 1'b1, 1'b0};
    lo1    = {attr.ri, attr.xi, 4'b0000, pa_odd[31:12], 3'b101, attr.d, 1'b1, 1'b0};
    pm     = ps[MASK_W-1:0] - PAIR_MIN[MASK_W-1:0];
  end

endmodule

`default_nettype wire
